FILE: hw/rtl/nnup_pkg.sv
// Shared types and constants for the nearest-neighbor upscaler.
package nnup_pkg;

	localparam int ACTION_W    = 1;
	localparam int COLOR_W     = 8;
	localparam int KIND_W      = 2;
	localparam int IN_WIDTH_W  = 11;
	localparam int IN_HEIGHT_W = 16;
	localparam int SCALE_W     = 7;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 16;
	localparam int PIXEL_W     = 3 * COLOR_W;

	localparam logic [ACTION_W-1:0] ACT_PUSH = 1'b0;
	localparam logic [ACTION_W-1:0] ACT_PULL = 1'b1;

	localparam logic [KIND_W-1:0] KIND_NONE    = 2'd0;
	localparam logic [KIND_W-1:0] KIND_PIXEL   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_PAD     = 2'd2;
	localparam logic [KIND_W-1:0] KIND_REFUSED = 2'd3;

	localparam logic [CFG_INDEX_W-1:0] REG_IN_WIDTH  = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_IN_HEIGHT = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_SCALE     = 2'd2;

	typedef struct packed {
		logic [ACTION_W-1:0] action;
		logic [COLOR_W-1:0]  in_blue;
		logic [COLOR_W-1:0]  in_green;
		logic [COLOR_W-1:0]  in_red;
	} in_item_t;

	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [COLOR_W-1:0] out_blue;
		logic [COLOR_W-1:0] out_green;
		logic [COLOR_W-1:0] out_red;
		logic               row_end;
		logic               image_end;
	} out_item_t;

	typedef struct packed {
		logic push;
		logic pull;
	} cmd_t;

endpackage

FILE: hw/rtl/nnup_ram.sv
// Generic single-port-write, registered-read RAM.
module nnup_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: hw/rtl/nnup_ctrl.sv
// Command controller: accepts a beat, then strobes its result in the next cycle.
module nnup_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [nnup_pkg::ACTION_W-1:0] action,
	output nnup_pkg::cmd_t                cmd,
	output logic                          busy,
	output logic                          done
);

	typedef enum logic {
		ST_IDLE,
		ST_EMIT
	} state_t;

	state_t state_q;
	logic   busy_q;
	logic   done_q;
	logic   accept;

	assign accept   = start && !busy_q;
	assign cmd.push = accept && (action == nnup_pkg::ACT_PUSH);
	assign cmd.pull = accept && (action == nnup_pkg::ACT_PULL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_EMIT;
						busy_q  <= 1'b1;
						done_q  <= 1'b1;
					end
				end
				ST_EMIT: begin
					state_q <= ST_IDLE;
					busy_q  <= 1'b0;
					done_q  <= 1'b0;
				end
				default: begin
					state_q <= ST_IDLE;
					busy_q  <= 1'b0;
					done_q  <= 1'b0;
				end
			endcase
		end
	end

	assign busy = busy_q;
	assign done = done_q;

endmodule

FILE: hw/rtl/nnup_dp.sv
// Datapath: configuration registers, line store, row and column counters.
module nnup_dp #(
	parameter int MAX_WIDTH = 1024,
	parameter int MAX_SCALE = 100
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  nnup_pkg::cmd_t                   cmd,
	input  nnup_pkg::in_item_t               command,
	input  logic                             cfg_we,
	input  logic [nnup_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [nnup_pkg::CFG_DATA_W-1:0]  cfg_data,
	output nnup_pkg::out_item_t              result
);

	localparam int CW = $clog2(MAX_WIDTH + 1);
	localparam int SW = $clog2(MAX_SCALE + 1);
	localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

	logic [nnup_pkg::IN_WIDTH_W-1:0]  in_width_q;
	logic [nnup_pkg::IN_HEIGHT_W-1:0] in_height_q;
	logic [nnup_pkg::SCALE_W-1:0]     scale_q;

	logic [CW-1:0]                    load_col_q, read_col_q;
	logic                             row_ready_q;
	logic [SW-1:0]                    across_q, down_q;
	logic [1:0]                       pad_q;
	logic [nnup_pkg::IN_HEIGHT_W-1:0] rows_done_q;

	logic [nnup_pkg::KIND_W-1:0]      kind_q;
	logic                             row_end_q, image_end_q;

	logic [CW-1:0]                    w_eff;
	logic [SW-1:0]                    s_eff;
	logic [nnup_pkg::IN_HEIGHT_W-1:0] h_eff;
	logic [1:0]                       w_lo, s_lo, prod_lo, pad_need;

	logic [CW-1:0]                    load_col_d, read_col_d;
	logic                             row_ready_d;
	logic [SW-1:0]                    across_d, down_d;
	logic [1:0]                       pad_d;
	logic [nnup_pkg::IN_HEIGHT_W-1:0] rows_done_d;
	logic [nnup_pkg::KIND_W-1:0]      kind_d;
	logic                             row_end_d, image_end_d;

	logic [CW:0]                      load_inc, read_inc;
	logic [SW:0]                      across_inc, down_inc;
	logic [2:0]                       pad_inc;
	logic [nnup_pkg::IN_HEIGHT_W:0]   rows_inc;
	logic                             finish;

	logic                             ram_we;
	logic [nnup_pkg::PIXEL_W-1:0]     ram_rdata;

	always_comb begin
		if (in_width_q == '0) begin
			w_eff = CW'(1);
		end else if (32'(in_width_q) > 32'(MAX_WIDTH)) begin
			w_eff = CW'(MAX_WIDTH);
		end else begin
			w_eff = CW'(in_width_q);
		end
		if (scale_q == '0) begin
			s_eff = SW'(1);
		end else if (32'(scale_q) > 32'(MAX_SCALE)) begin
			s_eff = SW'(MAX_SCALE);
		end else begin
			s_eff = SW'(scale_q);
		end
		h_eff = (in_height_q == '0) ? nnup_pkg::IN_HEIGHT_W'(1) : in_height_q;
	end

	assign w_lo     = 2'(w_eff);
	assign s_lo     = 2'(s_eff);
	assign prod_lo  = 2'(w_lo * s_lo * 2'd3);
	assign pad_need = 2'(2'd0 - prod_lo);

	assign load_inc   = {1'b0, load_col_q} + (CW + 1)'(1);
	assign read_inc   = {1'b0, read_col_q} + (CW + 1)'(1);
	assign across_inc = {1'b0, across_q} + (SW + 1)'(1);
	assign down_inc   = {1'b0, down_q} + (SW + 1)'(1);
	assign pad_inc    = {1'b0, pad_q} + 3'd1;
	assign rows_inc   = {1'b0, rows_done_q} + (nnup_pkg::IN_HEIGHT_W + 1)'(1);

	always_comb begin
		load_col_d  = load_col_q;
		read_col_d  = read_col_q;
		row_ready_d = row_ready_q;
		across_d    = across_q;
		down_d      = down_q;
		pad_d       = pad_q;
		rows_done_d = rows_done_q;
		kind_d      = nnup_pkg::KIND_NONE;
		row_end_d   = 1'b0;
		image_end_d = 1'b0;
		ram_we      = 1'b0;
		finish      = 1'b0;

		if (cmd.push) begin
			if (row_ready_q) begin
				kind_d = nnup_pkg::KIND_REFUSED;
			end else begin
				ram_we = 1'b1;
				if (load_inc >= {1'b0, w_eff}) begin
					load_col_d  = '0;
					row_ready_d = 1'b1;
					read_col_d  = '0;
					across_d    = '0;
					down_d      = '0;
					pad_d       = '0;
				end else begin
					load_col_d = CW'(load_inc);
				end
			end
		end else if (cmd.pull && row_ready_q) begin
			if (read_col_q < w_eff) begin
				kind_d = nnup_pkg::KIND_PIXEL;
				if (across_inc >= {1'b0, s_eff}) begin
					across_d   = '0;
					read_col_d = CW'(read_inc);
					if (read_inc >= {1'b0, w_eff} && pad_need == 2'd0) begin
						finish = 1'b1;
					end
				end else begin
					across_d = SW'(across_inc);
				end
			end else begin
				kind_d = nnup_pkg::KIND_PAD;
				pad_d  = 2'(pad_inc);
				if (pad_inc >= {1'b0, pad_need}) begin
					finish = 1'b1;
				end
			end
		end

		if (finish) begin
			row_end_d  = 1'b1;
			read_col_d = '0;
			across_d   = '0;
			pad_d      = '0;
			if (down_inc >= {1'b0, s_eff}) begin
				down_d      = '0;
				row_ready_d = 1'b0;
				if (rows_inc >= {1'b0, h_eff}) begin
					rows_done_d = '0;
					image_end_d = 1'b1;
				end else begin
					rows_done_d = nnup_pkg::IN_HEIGHT_W'(rows_inc);
				end
			end else begin
				down_d = SW'(down_inc);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_width_q  <= nnup_pkg::IN_WIDTH_W'(1);
			in_height_q <= nnup_pkg::IN_HEIGHT_W'(1);
			scale_q     <= nnup_pkg::SCALE_W'(1);
			load_col_q  <= '0;
			read_col_q  <= '0;
			row_ready_q <= 1'b0;
			across_q    <= '0;
			down_q      <= '0;
			pad_q       <= '0;
			rows_done_q <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					nnup_pkg::REG_IN_WIDTH: begin
						in_width_q <= cfg_data[nnup_pkg::IN_WIDTH_W-1:0];
					end
					nnup_pkg::REG_IN_HEIGHT: begin
						in_height_q <= cfg_data[nnup_pkg::IN_HEIGHT_W-1:0];
					end
					nnup_pkg::REG_SCALE: begin
						scale_q <= cfg_data[nnup_pkg::SCALE_W-1:0];
					end
					default: begin
					end
				endcase
			end
			load_col_q  <= load_col_d;
			read_col_q  <= read_col_d;
			row_ready_q <= row_ready_d;
			across_q    <= across_d;
			down_q      <= down_d;
			pad_q       <= pad_d;
			rows_done_q <= rows_done_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push || cmd.pull) begin
			kind_q      <= kind_d;
			row_end_q   <= row_end_d;
			image_end_q <= image_end_d;
		end
	end

	nnup_ram #(
		.WIDTH(nnup_pkg::PIXEL_W),
		.DEPTH(MAX_WIDTH)
	) u_line_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(AW'(load_col_q)),
		.wdata({command.in_blue, command.in_green, command.in_red}),
		.raddr(AW'(read_col_q)),
		.rdata(ram_rdata)
	);

	always_comb begin
		result.kind      = kind_q;
		result.row_end   = row_end_q;
		result.image_end = image_end_q;
		if (kind_q == nnup_pkg::KIND_PIXEL) begin
			result.out_blue  = ram_rdata[3*nnup_pkg::COLOR_W-1:2*nnup_pkg::COLOR_W];
			result.out_green = ram_rdata[2*nnup_pkg::COLOR_W-1:nnup_pkg::COLOR_W];
			result.out_red   = ram_rdata[nnup_pkg::COLOR_W-1:0];
		end else begin
			result.out_blue  = '0;
			result.out_green = '0;
			result.out_red   = '0;
		end
	end

endmodule

FILE: hw/rtl/nearest_neighbour_upscaler_unit.sv
// Top level of the nearest-neighbor integer upscaler.
// Every command is accepted at the edge where start is high and busy is low;
// its one result beat is on result for the next cycle, marked by done, while
// busy is high, and busy drops after that cycle; the next command is taken only
// once busy is low. The result is registered, as is the read of the single
// line-store RAM (MAX_WIDTH pixels of 24 bits). The receiver cannot stall, so
// every command yields exactly one beat, including a kind of "none" for an
// idle pull and "refused" for a push while a row drains. Configuration writes
// are always ready and are to be made between commands; the line store needs
// no clearing after reset.
module nearest_neighbour_upscaler_unit #(
	parameter int MAX_WIDTH = 1024,
	parameter int MAX_SCALE = 100
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  nnup_pkg::in_item_t               command,
	output logic                             done,
	output nnup_pkg::out_item_t              result,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [nnup_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [nnup_pkg::CFG_DATA_W-1:0]  cfg_data
);

	nnup_pkg::cmd_t cmd;

	assign cfg_ready = 1'b1;

	nnup_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.action(command.action),
		.cmd   (cmd),
		.busy  (busy),
		.done  (done)
	);

	nnup_dp #(
		.MAX_WIDTH(MAX_WIDTH),
		.MAX_SCALE(MAX_SCALE)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.command  (command),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.result   (result)
	);

endmodule

FILE: hw/rtl/nnup_chk.sv
// Port-level checker for the upscaler, bound to the top level.
module nnup_chk (
	input logic                clk,
	input logic                arst_n,
	input logic                start,
	input logic                busy,
	input logic                done,
	input nnup_pkg::out_item_t result
);

	a_done_follows_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> done)
		else $error("accepted command produced no result beat");

	a_done_has_cause: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy))
		else $error("result beat without an accepted command");

	a_one_beat: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result beat repeated");

	a_color_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.kind != nnup_pkg::KIND_PIXEL) |->
		(result.out_blue == '0 && result.out_green == '0 && result.out_red == '0))
		else $error("color bytes nonzero on a non-pixel beat");

	a_image_end_row_end: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.image_end) |-> (result.row_end &&
		(result.kind == nnup_pkg::KIND_PIXEL || result.kind == nnup_pkg::KIND_PAD)))
		else $error("image end without row end on an output beat");

endmodule

bind nearest_neighbour_upscaler_unit nnup_chk u_nnup_chk (
	.clk   (clk),
	.arst_n(arst_n),
	.start (start),
	.busy  (busy),
	.done  (done),
	.result(result)
);

FILE: test/tb_nearest_neighbour_upscaler_unit.sv
// Self-checking testbench for the nearest-neighbor upscaler unit.
module tb_nearest_neighbour_upscaler_unit;

	localparam int MAX_W = 1024;
	localparam int MAX_S = 100;
	localparam int LINE_AW = $clog2(MAX_W);
	localparam int CYCLE_LIMIT = 2_000_000;
	localparam int RANDOM_ITEMS = 700;
	localparam logic [nnup_pkg::CFG_INDEX_W-1:0] REG_SPARE = 2'd3;

	logic                             clk;
	logic                             arst_n;
	logic                             start;
	logic                             busy;
	nnup_pkg::in_item_t               command;
	logic                             done;
	nnup_pkg::out_item_t              result;
	logic                             cfg_valid;
	logic                             cfg_ready;
	logic [nnup_pkg::CFG_INDEX_W-1:0] cfg_index;
	logic [nnup_pkg::CFG_DATA_W-1:0]  cfg_data;

	nearest_neighbour_upscaler_unit #(
		.MAX_WIDTH(MAX_W),
		.MAX_SCALE(MAX_S)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.command(command),
		.done(done),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// predictor state
	logic [nnup_pkg::IN_WIDTH_W-1:0]  cfg_width;
	logic [nnup_pkg::IN_HEIGHT_W-1:0] cfg_height;
	logic [nnup_pkg::SCALE_W-1:0]     cfg_scale;
	logic [nnup_pkg::PIXEL_W-1:0]     line_copy [MAX_W];
	logic [nnup_pkg::IN_WIDTH_W-1:0]  load_col;
	logic                             row_ready;
	logic [nnup_pkg::IN_WIDTH_W-1:0]  rd_col;
	logic [nnup_pkg::SCALE_W-1:0]     across_n;
	logic [nnup_pkg::SCALE_W-1:0]     down_n;
	logic [1:0]                       pad_n;
	logic [nnup_pkg::IN_HEIGHT_W-1:0] rows_done;
	int                               filled;

	nnup_pkg::out_item_t pending_q [$];
	int                  mismatch_n;
	int                  beat_n;
	int                  useful_n;
	int                  cycle_n;
	logic                calm;

	initial clk = 1'b0;
	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycle_n <= cycle_n + 1;
		if (cycle_n > CYCLE_LIMIT) begin
			$display("nearest_neighbour_upscaler_unit regression: fail");
			$finish;
		end
	end

	task automatic report_mismatch(input string msg);
		mismatch_n++;
		if (mismatch_n <= 40)
			$display("mismatch at beat %0d: %s", beat_n, msg);
	endtask

	function automatic int unsigned eff_width();
		if (cfg_width < 1) return 1;
		if (cfg_width > MAX_W) return MAX_W;
		return 32'(cfg_width);
	endfunction

	function automatic int unsigned eff_height();
		return (cfg_height == 0) ? 1 : 32'(cfg_height);
	endfunction

	function automatic int unsigned eff_scale();
		if (cfg_scale < 1) return 1;
		if (cfg_scale > MAX_S) return MAX_S;
		return 32'(cfg_scale);
	endfunction

	function automatic int unsigned pad_len();
		int unsigned bytes;
		bytes = eff_width() * eff_scale() * 3;
		return (4 - (bytes & 3)) & 3;
	endfunction

	task automatic close_row(output logic last);
		last = 1'b0;
		rd_col = '0;
		across_n = '0;
		pad_n = '0;
		down_n++;
		if (down_n >= eff_scale()) begin
			down_n = '0;
			row_ready = 1'b0;
			if (rows_done + 1 >= eff_height()) begin
				rows_done = '0;
				last = 1'b1;
			end else begin
				rows_done++;
			end
		end
	endtask

	task automatic upscale_step(input nnup_pkg::in_item_t c, output nnup_pkg::out_item_t r);
		int unsigned w;
		int unsigned s;
		int unsigned pads;
		r = '0;
		w = eff_width();
		s = eff_scale();
		pads = pad_len();
		if (c.action == nnup_pkg::ACT_PUSH) begin
			if (row_ready) begin
				r.kind = nnup_pkg::KIND_REFUSED;
			end else begin
				line_copy[LINE_AW'(load_col)] = {c.in_blue, c.in_green, c.in_red};
				if (load_col + 1 > filled) filled = load_col + 1;
				if (load_col + 1 >= w) begin
					load_col = '0;
					row_ready = 1'b1;
					rd_col = '0;
					across_n = '0;
					down_n = '0;
					pad_n = '0;
				end else begin
					load_col++;
				end
			end
		end else if (row_ready) begin
			if (rd_col < w) begin
				r.kind = nnup_pkg::KIND_PIXEL;
				{r.out_blue, r.out_green, r.out_red} = line_copy[LINE_AW'(rd_col)];
				across_n++;
				if (across_n >= s) begin
					across_n = '0;
					rd_col++;
					if (rd_col >= w && pads == 0) begin
						r.row_end = 1'b1;
						close_row(r.image_end);
					end
				end
			end else begin
				r.kind = nnup_pkg::KIND_PAD;
				pad_n++;
				if (pad_n >= pads) begin
					r.row_end = 1'b1;
					close_row(r.image_end);
				end
			end
		end
	endtask

	always @(posedge clk) begin : check_results
		nnup_pkg::out_item_t want;
		if (arst_n && done) begin
			if (pending_q.size() == 0) begin
				report_mismatch("beat with nothing expected");
			end else begin
				want = pending_q.pop_front();
				if (result.kind !== want.kind)
					report_mismatch($sformatf("kind %0h want %0h", result.kind, want.kind));
				if (result.out_blue !== want.out_blue)
					report_mismatch($sformatf("blue %0h want %0h", result.out_blue,
						want.out_blue));
				if (result.out_green !== want.out_green)
					report_mismatch($sformatf("green %0h want %0h", result.out_green,
						want.out_green));
				if (result.out_red !== want.out_red)
					report_mismatch($sformatf("red %0h want %0h", result.out_red,
						want.out_red));
				if (result.row_end !== want.row_end)
					report_mismatch($sformatf("row_end %0b want %0b", result.row_end,
						want.row_end));
				if (result.image_end !== want.image_end)
					report_mismatch($sformatf("image_end %0b want %0b", result.image_end,
						want.image_end));
			end
			beat_n++;
		end
	end

	function automatic nnup_pkg::in_item_t push_cmd(input logic [7:0] b, g, r);
		nnup_pkg::in_item_t c;
		c.action = nnup_pkg::ACT_PUSH;
		c.in_blue = b;
		c.in_green = g;
		c.in_red = r;
		return c;
	endfunction

	function automatic nnup_pkg::in_item_t random_cmd(
		input logic [nnup_pkg::ACTION_W-1:0] act);
		nnup_pkg::in_item_t c;
		c.action = act;
		c.in_blue = 8'($urandom);
		c.in_green = 8'($urandom);
		c.in_red = 8'($urandom);
		return c;
	endfunction

	task automatic send_item(input nnup_pkg::in_item_t c);
		nnup_pkg::out_item_t want;
		int gap;
		gap = (!calm && $urandom_range(99) < 37) ? $urandom_range(1, 4) : 0;
		repeat (gap) begin
			@(negedge clk);
			start <= 1'b0;
		end
		@(negedge clk);
		start <= 1'b1;
		command <= c;
		do @(posedge clk); while (busy);
		if ((c.action == nnup_pkg::ACT_PUSH) != row_ready) useful_n++;
		upscale_step(c, want);
		pending_q.push_back(want);
	endtask

	// hold off until every beat is back and the unit is quiet
	task automatic settle();
		@(negedge clk);
		start <= 1'b0;
		while (pending_q.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_reg(input logic [nnup_pkg::CFG_INDEX_W-1:0] idx,
		input logic [nnup_pkg::CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			nnup_pkg::REG_IN_WIDTH: cfg_width = val[nnup_pkg::IN_WIDTH_W-1:0];
			nnup_pkg::REG_IN_HEIGHT: cfg_height = val[nnup_pkg::IN_HEIGHT_W-1:0];
			nnup_pkg::REG_SCALE: cfg_scale = val[nnup_pkg::SCALE_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic load_row(input int noise_pct);
		while (!row_ready)
			send_item(random_cmd(($urandom_range(99) < noise_pct) ?
				nnup_pkg::ACT_PULL : nnup_pkg::ACT_PUSH));
	endtask

	task automatic drain_rows(input int noise_pct);
		while (row_ready)
			send_item(random_cmd(($urandom_range(99) < noise_pct) ?
				nnup_pkg::ACT_PUSH : nnup_pkg::ACT_PULL));
	endtask

	task automatic test_directed();
		write_reg(nnup_pkg::REG_IN_WIDTH, 16'd2);
		write_reg(nnup_pkg::REG_IN_HEIGHT, 16'd1);
		write_reg(nnup_pkg::REG_SCALE, 16'd2);
		send_item(random_cmd(nnup_pkg::ACT_PULL));
		send_item(push_cmd(8'h00, 8'h00, 8'h00));
		send_item(push_cmd(8'hff, 8'hff, 8'hff));
		send_item(random_cmd(nnup_pkg::ACT_PUSH));
		drain_rows(0);
		send_item(random_cmd(nnup_pkg::ACT_PULL));
		settle();
		write_reg(nnup_pkg::REG_IN_WIDTH, 16'd1);
		write_reg(nnup_pkg::REG_SCALE, 16'd1);
		send_item(push_cmd(8'ha5, 8'h5a, 8'hc3));
		drain_rows(0);
		settle();
	endtask

	task automatic test_register_extremes();
		write_reg(nnup_pkg::REG_IN_WIDTH, 16'd0);
		write_reg(nnup_pkg::REG_IN_HEIGHT, 16'd0);
		write_reg(nnup_pkg::REG_SCALE, 16'd0);
		load_row(0);
		drain_rows(0);
		settle();
		write_reg(REG_SPARE, 16'hffff);
		write_reg(nnup_pkg::REG_IN_WIDTH, 16'hffff);
		write_reg(nnup_pkg::REG_IN_HEIGHT, 16'hffff);
		write_reg(nnup_pkg::REG_SCALE, 16'd1);
		repeat (3) send_item(random_cmd(nnup_pkg::ACT_PUSH));
		settle();
		write_reg(nnup_pkg::REG_IN_WIDTH, 16'd2);
		load_row(0);
		drain_rows(0);
		settle();
		write_reg(nnup_pkg::REG_IN_WIDTH, 16'd1);
		write_reg(nnup_pkg::REG_IN_HEIGHT, 16'd1);
		write_reg(nnup_pkg::REG_SCALE, 16'h007f);
		load_row(0);
		drain_rows(0);
		settle();
	endtask

	task automatic test_mid_row_changes();
		write_reg(nnup_pkg::REG_IN_WIDTH, 16'd4);
		write_reg(nnup_pkg::REG_IN_HEIGHT, 16'd2);
		write_reg(nnup_pkg::REG_SCALE, 16'd3);
		load_row(0);
		repeat (5) send_item(random_cmd(nnup_pkg::ACT_PULL));
		settle();
		write_reg(nnup_pkg::REG_SCALE, 16'd1);
		repeat (3) send_item(random_cmd(nnup_pkg::ACT_PULL));
		settle();
		write_reg(nnup_pkg::REG_IN_WIDTH, 16'd2);
		write_reg(nnup_pkg::REG_IN_HEIGHT, 16'd1);
		drain_rows(0);
		settle();
		write_reg(nnup_pkg::REG_IN_WIDTH, 16'd5);
		repeat (2) send_item(random_cmd(nnup_pkg::ACT_PUSH));
		settle();
		write_reg(nnup_pkg::REG_IN_WIDTH, 16'd2);
		load_row(0);
		drain_rows(0);
		settle();
	endtask

	task automatic test_random_images();
		int target;
		int img;
		int w;
		int s;
		int h;
		target = useful_n + RANDOM_ITEMS;
		img = 0;
		while (useful_n < target) begin
			calm = (img >= 4 && img < 9);
			w = ($urandom_range(9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
			s = ($urandom_range(9) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
			h = $urandom_range(1, 3);
			settle();
			write_reg(nnup_pkg::REG_IN_WIDTH,
				16'(w) | (16'($urandom_range(31)) << nnup_pkg::IN_WIDTH_W));
			write_reg(nnup_pkg::REG_IN_HEIGHT, 16'(h));
			write_reg(nnup_pkg::REG_SCALE,
				16'(s) | (16'($urandom_range(511)) << nnup_pkg::SCALE_W));
			repeat (h) begin
				load_row(10);
				if (img == 2) settle();
				drain_rows(10);
			end
			img++;
		end
		calm = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		command = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		calm = 1'b0;
		mismatch_n = 0;
		beat_n = 0;
		useful_n = 0;
		cycle_n = 0;
		cfg_width = 11'd1;
		cfg_height = 16'd1;
		cfg_scale = 7'd1;
		load_col = '0;
		row_ready = 1'b0;
		rd_col = '0;
		across_n = '0;
		down_n = '0;
		pad_n = '0;
		rows_done = '0;
		filled = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_register_extremes();
		test_mid_row_changes();
		test_random_images();

		settle();
		repeat (4) @(posedge clk);
		if (mismatch_n == 0) begin
			$display("nearest_neighbour_upscaler_unit regression: pass");
		end else begin
			$display("nearest_neighbour_upscaler_unit regression: fail");
		end
		$finish;
	end

endmodule
